[sv/sidt_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the handle table.
package sidt_pkg;

  localparam int unsigned DATA_DEPTH   = 1024;
  localparam int unsigned ID_DEPTH     = 4096;

  localparam int unsigned VALUE_W      = 64;
  localparam int unsigned HANDLE_W     = 32;
  localparam int unsigned SLOT_IN_W    = 10;
  localparam int unsigned RES_HANDLE_W = 12;
  localparam int unsigned RES_COUNT_W  = 11;

  localparam int unsigned SLOT_W       = $clog2(DATA_DEPTH);
  localparam int unsigned HID_W        = $clog2(ID_DEPTH);
  localparam int unsigned COUNT_W      = $clog2(DATA_DEPTH + 1);
  localparam int unsigned NEXT_W       = $clog2(ID_DEPTH + 1);
  localparam int unsigned MAP_W        = SLOT_W + 1;

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_LOOKUP    = 2'd1,
    OP_ERASE     = 2'd2,
    OP_READ_SLOT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROOM  = 2'd1,
    ST_NOT_LIVE = 2'd2,
    ST_BEYOND   = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_READ_MAP  = 6'b000010,
    S_READ_DATA = 6'b000100,
    S_WRITE_A   = 6'b001000,
    S_WRITE_B   = 6'b010000,
    S_RESP      = 6'b100000
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd_map;
    logic rd_data;
    logic wr_a;
    logic wr_b;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_e  new_op;
    op_e  op;
    logic hit;
    logic moves;
    logic out_busy;
  } sts_t;

endpackage

[sv/stable_id_dense_table.sv]
// Top level of the stable-handle dense table: controller plus datapath.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | opcode, push_value, handle, slot_index
//   out     | output    | out_valid_o / out_stall_i | status, result_handle, result_value,
//           |           |                           | live_count
//
// One beat at a time. A push passes through write A, a read-slot through the data read, a
// lookup or a dead-handle erase through the map read and the data read, and a live erase
// through the map read, the data read, write A and, when the last entry moves into the hole,
// write B; the response state then loads the output register. The input stays stalled until
// the sequencer is back in idle. Phases are set by the registered read ports of the handle
// map and value and owner stores, each read in its own state, and one write port per memory.
// A new beat is taken once the previous result is in the output register, even while that
// result is still stalled; a stalled output holds the sequencer in its response state.
// Reset clears the counters and handshake state only; there is no clearing pass. A handle
// at or above the issue counter reads as not live, so stale map contents are never used.
module stable_id_dense_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          opcode_i,
  input  logic [sidt_pkg::VALUE_W-1:0]        push_value_i,
  input  logic [sidt_pkg::HANDLE_W-1:0]       handle_i,
  input  logic [sidt_pkg::SLOT_IN_W-1:0]      slot_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [sidt_pkg::RES_HANDLE_W-1:0]   result_handle_o,
  output logic [sidt_pkg::VALUE_W-1:0]        result_value_o,
  output logic [sidt_pkg::RES_COUNT_W-1:0]    live_count_o
);

  sidt_pkg::cmd_t cmd;
  sidt_pkg::sts_t sts;

  // sequencer: decides which phase runs this cycle
  sidt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // maps, stores, counters and the output register
  sidt_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (opcode_i),
    .push_value_i    (push_value_i),
    .handle_i        (handle_i),
    .slot_index_i    (slot_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .result_handle_o (result_handle_o),
    .result_value_o  (result_value_o),
    .live_count_o    (live_count_o)
  );

endmodule

[sv/sidt_datapath.sv]
// Datapath: operand registers, handle/slot maps, value store, counters and result register.
module sidt_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sidt_pkg::cmd_t                      cmd_i,
  output sidt_pkg::sts_t                      sts_o,
  input  logic [1:0]                          opcode_i,
  input  logic [sidt_pkg::VALUE_W-1:0]        push_value_i,
  input  logic [sidt_pkg::HANDLE_W-1:0]       handle_i,
  input  logic [sidt_pkg::SLOT_IN_W-1:0]      slot_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [sidt_pkg::RES_HANDLE_W-1:0]   result_handle_o,
  output logic [sidt_pkg::VALUE_W-1:0]        result_value_o,
  output logic [sidt_pkg::RES_COUNT_W-1:0]    live_count_o
);

  // operands of the beat in flight
  sidt_pkg::op_e                       op_q;
  logic [sidt_pkg::VALUE_W-1:0]        val_q;
  logic [sidt_pkg::HANDLE_W-1:0]       h_q;
  logic [sidt_pkg::SLOT_IN_W-1:0]      si_q;

  // memories
  logic [sidt_pkg::VALUE_W-1:0]        value_mem [sidt_pkg::DATA_DEPTH];
  logic [sidt_pkg::HID_W-1:0]          owner_mem [sidt_pkg::DATA_DEPTH];
  logic [sidt_pkg::MAP_W-1:0]          map_mem   [sidt_pkg::ID_DEPTH];

  logic [sidt_pkg::VALUE_W-1:0]        vrd_q;
  logic [sidt_pkg::HID_W-1:0]          ord_q;
  logic [sidt_pkg::MAP_W-1:0]          map_rd_q;

  // control state
  logic [sidt_pkg::COUNT_W-1:0]        count_q, count_d;
  logic [sidt_pkg::NEXT_W-1:0]         next_q, next_d;
  logic                                ok_q;
  logic [sidt_pkg::SLOT_W-1:0]         slot_q;
  logic [sidt_pkg::HID_W-1:0]          rh_q;

  logic                                out_valid_q;
  logic [1:0]                          status_q;
  logic [sidt_pkg::RES_HANDLE_W-1:0]   res_handle_q;
  logic [sidt_pkg::VALUE_W-1:0]        res_value_q;
  logic [sidt_pkg::RES_COUNT_W-1:0]    res_count_q;

  // derived
  logic                                map_live;
  logic [sidt_pkg::SLOT_W-1:0]         map_slot;
  logic [sidt_pkg::SLOT_W-1:0]         last_slot;
  logic                                handle_ok, room, in_range, hit, moves;
  logic [sidt_pkg::SLOT_W-1:0]         data_addr;

  logic                                vs_we, ow_we, hm_we;
  logic [sidt_pkg::SLOT_W-1:0]         vs_addr, ow_addr;
  logic [sidt_pkg::HID_W-1:0]          hm_addr;
  logic [sidt_pkg::VALUE_W-1:0]        vs_wdata;
  logic [sidt_pkg::HID_W-1:0]          ow_wdata;
  logic [sidt_pkg::MAP_W-1:0]          hm_wdata;

  sidt_pkg::status_e                   res_status;
  logic [sidt_pkg::RES_HANDLE_W-1:0]   res_handle;
  logic [sidt_pkg::VALUE_W-1:0]        res_value;

  assign map_live  = map_rd_q[sidt_pkg::SLOT_W];
  assign map_slot  = map_rd_q[sidt_pkg::SLOT_W-1:0];
  assign last_slot = sidt_pkg::SLOT_W'(count_q - sidt_pkg::COUNT_W'(1));

  // handles at or above the issue counter were never written: not live
  assign handle_ok = (h_q < sidt_pkg::HANDLE_W'(next_q)) && map_live &&
                     (count_q != '0);
  assign room      = (count_q != sidt_pkg::COUNT_W'(sidt_pkg::DATA_DEPTH)) &&
                     (next_q != sidt_pkg::NEXT_W'(sidt_pkg::ID_DEPTH));
  assign in_range  = sidt_pkg::COUNT_W'(si_q) < count_q;
  assign moves     = slot_q != last_slot;

  always_comb begin
    case (op_q)
      sidt_pkg::OP_PUSH:      hit = room;
      sidt_pkg::OP_READ_SLOT: hit = in_range;
      default:                hit = handle_ok;
    endcase
  end

  assign sts_o.new_op   = sidt_pkg::op_e'(opcode_i);
  assign sts_o.op       = op_q;
  assign sts_o.hit      = hit;
  assign sts_o.moves    = moves;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= sidt_pkg::op_e'(opcode_i);
      val_q <= push_value_i;
      h_q   <= handle_i;
      si_q  <= slot_index_i;
    end
  end

  // data read address: mapped slot, last slot or the requested slot
  always_comb begin
    case (op_q)
      sidt_pkg::OP_LOOKUP: data_addr = map_slot;
      sidt_pkg::OP_ERASE:  data_addr = last_slot;
      default:             data_addr = sidt_pkg::SLOT_W'(si_q);
    endcase
  end

  // write ports
  always_comb begin
    vs_we    = 1'b0;
    ow_we    = 1'b0;
    hm_we    = 1'b0;
    vs_addr  = slot_q;
    ow_addr  = slot_q;
    hm_addr  = ord_q;
    vs_wdata = vrd_q;
    ow_wdata = ord_q;
    hm_wdata = {1'b1, slot_q};
    if (cmd_i.wr_a) begin
      if (op_q == sidt_pkg::OP_PUSH) begin
        vs_we    = room;
        ow_we    = room;
        hm_we    = room;
        vs_addr  = sidt_pkg::SLOT_W'(count_q);
        ow_addr  = sidt_pkg::SLOT_W'(count_q);
        hm_addr  = sidt_pkg::HID_W'(next_q);
        vs_wdata = val_q;
        ow_wdata = sidt_pkg::HID_W'(next_q);
        hm_wdata = {1'b1, sidt_pkg::SLOT_W'(count_q)};
      end else begin
        // erase: last entry fills the hole, freed handle goes dead
        vs_we    = moves;
        ow_we    = moves;
        hm_we    = 1'b1;
        hm_addr  = h_q[sidt_pkg::HID_W-1:0];
        hm_wdata = {1'b0, slot_q};
      end
    end else if (cmd_i.wr_b) begin
      hm_we = 1'b1;  // moved handle now points at the hole
    end
  end

  always_ff @(posedge clk_i) begin
    if (vs_we) value_mem[vs_addr] <= vs_wdata;
    if (ow_we) owner_mem[ow_addr] <= ow_wdata;
    if (hm_we) map_mem[hm_addr]   <= hm_wdata;
    if (cmd_i.rd_map) map_rd_q <= map_mem[h_q[sidt_pkg::HID_W-1:0]];
    if (cmd_i.rd_data) begin
      vrd_q <= value_mem[data_addr];
      ord_q <= owner_mem[data_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_data) slot_q <= map_slot;
    if (cmd_i.wr_a && op_q == sidt_pkg::OP_PUSH) rh_q <= sidt_pkg::HID_W'(next_q);
  end

  always_comb begin
    count_d = count_q;
    next_d  = next_q;
    if (cmd_i.wr_a) begin
      if (op_q == sidt_pkg::OP_PUSH) begin
        if (room) begin
          count_d = count_q + sidt_pkg::COUNT_W'(1);
          next_d  = next_q + sidt_pkg::NEXT_W'(1);
        end
      end else begin
        count_d = count_q - sidt_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      next_q  <= '0;
      ok_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      next_q  <= next_d;
      if (cmd_i.rd_data || (cmd_i.wr_a && op_q == sidt_pkg::OP_PUSH)) ok_q <= hit;
    end
  end

  // result formation
  always_comb begin
    res_status = sidt_pkg::ST_OK;
    res_handle = '0;
    res_value  = '0;
    case (op_q) inside
      sidt_pkg::OP_PUSH: begin
        if (ok_q) res_handle = sidt_pkg::RES_HANDLE_W'(rh_q);
        else      res_status = sidt_pkg::ST_NO_ROOM;
      end
      sidt_pkg::OP_LOOKUP, sidt_pkg::OP_ERASE: begin
        if (!ok_q) res_status = sidt_pkg::ST_NOT_LIVE;
        else if (op_q == sidt_pkg::OP_LOOKUP) res_value = vrd_q;
      end
      default: begin
        if (ok_q) begin
          res_handle = sidt_pkg::RES_HANDLE_W'(ord_q);
          res_value  = vrd_q;
        end else begin
          res_status = sidt_pkg::ST_BEYOND;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q     <= res_status;
      res_handle_q <= res_handle;
      res_value_q  <= res_value;
      res_count_q  <= sidt_pkg::RES_COUNT_W'(count_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_handle_o = res_handle_q;
  assign result_value_o  = res_value_q;
  assign live_count_o    = res_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sidt_pkg::COUNT_W'(sidt_pkg::DATA_DEPTH))
    else $error("live count above capacity");

  a_next_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= sidt_pkg::NEXT_W'(sidt_pkg::ID_DEPTH))
    else $error("handle counter above handle space");

  a_count_le_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sidt_pkg::NEXT_W'(count_q) <= next_q)
    else $error("more live entries than handles issued");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_a && op_q == sidt_pkg::OP_PUSH && room) |=>
      (count_q == $past(count_q) + sidt_pkg::COUNT_W'(1)))
    else $error("push did not grow the live count");

endmodule

[sv/sidt_ctrl.sv]
// Controller: one-hot sequencer for each beat's map read, data read and writes as needed.
module sidt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sidt_pkg::sts_t sts_i,
  output sidt_pkg::cmd_t cmd_o
);

  sidt_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sidt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.new_op)
            sidt_pkg::OP_PUSH:      state_d = sidt_pkg::S_WRITE_A;
            sidt_pkg::OP_READ_SLOT: state_d = sidt_pkg::S_READ_DATA;
            default:                state_d = sidt_pkg::S_READ_MAP;
          endcase
        end
      end
      sidt_pkg::S_READ_MAP:  state_d = sidt_pkg::S_READ_DATA;
      sidt_pkg::S_READ_DATA: begin
        if (sts_i.op == sidt_pkg::OP_ERASE && sts_i.hit) state_d = sidt_pkg::S_WRITE_A;
        else                                             state_d = sidt_pkg::S_RESP;
      end
      sidt_pkg::S_WRITE_A: begin
        if (sts_i.op == sidt_pkg::OP_ERASE && sts_i.moves) state_d = sidt_pkg::S_WRITE_B;
        else                                               state_d = sidt_pkg::S_RESP;
      end
      sidt_pkg::S_WRITE_B:   state_d = sidt_pkg::S_RESP;
      sidt_pkg::S_RESP: begin
        if (!sts_i.out_busy) state_d = sidt_pkg::S_IDLE;
      end
      default:               state_d = sidt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sidt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o     = state_q != sidt_pkg::S_IDLE;
  assign cmd_o.accept   = (state_q == sidt_pkg::S_IDLE) && in_valid_i;
  assign cmd_o.rd_map   = state_q == sidt_pkg::S_READ_MAP;
  assign cmd_o.rd_data  = state_q == sidt_pkg::S_READ_DATA;
  assign cmd_o.wr_a     = state_q == sidt_pkg::S_WRITE_A;
  assign cmd_o.wr_b     = state_q == sidt_pkg::S_WRITE_B;
  assign cmd_o.load_out = (state_q == sidt_pkg::S_RESP) && !sts_i.out_busy;

  a_wr_b_after_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sidt_pkg::S_WRITE_B) |-> (sts_i.op == sidt_pkg::OP_ERASE))
    else $error("second map write outside an erase");

  a_write_after_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sidt_pkg::S_WRITE_A) |->
      ($past(state_q) == sidt_pkg::S_IDLE || $past(state_q) == sidt_pkg::S_READ_DATA))
    else $error("write phase entered out of order");

endmodule

[test/stable_id_dense_table_tb.sv]
// Self-checking testbench for the stable-handle dense table.
`timescale 1ns / 100ps

module stable_id_dense_table_tb;

  // Bits of a wild handle above the handle space
  localparam int unsigned HIGH_W = sidt_pkg::HANDLE_W - sidt_pkg::HID_W;

  // One result beat as the block should present it
  typedef struct {
    sidt_pkg::status_e                 status;
    logic [sidt_pkg::RES_HANDLE_W-1:0] handle;
    logic [sidt_pkg::VALUE_W-1:0]      value;
    logic [sidt_pkg::RES_COUNT_W-1:0]  count;
  } table_result_t;

  // Mirrors the table contents and queues the expected result of each accepted input beat.
  class handle_table_scoreboard;
    bit [sidt_pkg::VALUE_W-1:0]      value_store [sidt_pkg::DATA_DEPTH];
    bit [sidt_pkg::RES_HANDLE_W-1:0] slot_owner  [sidt_pkg::DATA_DEPTH];
    bit [sidt_pkg::SLOT_W-1:0]       handle_slot [sidt_pkg::ID_DEPTH];
    bit                              handle_live [sidt_pkg::ID_DEPTH];
    int unsigned                     n_live;
    int unsigned                     next_id;
    table_result_t                   expected_results[$];
    int unsigned                     n_results;
    int unsigned                     n_mismatches;

    task report_mismatch(string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      n_mismatches++;
    endtask

    function table_result_t predict_table_op(sidt_pkg::op_e op,
                                             logic [sidt_pkg::VALUE_W-1:0] v,
                                             logic [sidt_pkg::HANDLE_W-1:0] h,
                                             logic [sidt_pkg::SLOT_IN_W-1:0] si);
      table_result_t r;
      bit [sidt_pkg::HID_W-1:0]  hid;
      bit [sidt_pkg::HID_W-1:0]  moved;
      bit [sidt_pkg::SLOT_W-1:0] slot;
      bit [sidt_pkg::SLOT_W-1:0] last;
      bit                        live;
      r = '{status: sidt_pkg::ST_OK, handle: '0, value: '0, count: '0};
      hid  = h[sidt_pkg::HID_W-1:0];
      live = (h < sidt_pkg::ID_DEPTH) && handle_live[hid];
      case (op)
        sidt_pkg::OP_PUSH: begin
          if (n_live >= sidt_pkg::DATA_DEPTH || next_id >= sidt_pkg::ID_DEPTH) begin
            r.status = sidt_pkg::ST_NO_ROOM;
          end else begin
            slot = n_live[sidt_pkg::SLOT_W-1:0];
            value_store[slot] = v;
            slot_owner[slot]  = next_id[sidt_pkg::RES_HANDLE_W-1:0];
            handle_slot[next_id] = slot;
            handle_live[next_id] = 1'b1;
            r.handle = next_id[sidt_pkg::RES_HANDLE_W-1:0];
            next_id++;
            n_live++;
          end
        end
        sidt_pkg::OP_LOOKUP: begin
          if (live) r.value = value_store[handle_slot[hid]];
          else r.status = sidt_pkg::ST_NOT_LIVE;
        end
        sidt_pkg::OP_ERASE: begin
          if (live && n_live > 0) begin
            slot = handle_slot[hid];
            last = sidt_pkg::SLOT_W'(n_live - 1);
            // swap-remove: last entry fills the hole unless it is the hole
            if (slot != last) begin
              moved = slot_owner[last][sidt_pkg::HID_W-1:0];
              value_store[slot] = value_store[last];
              slot_owner[slot]  = moved;
              handle_slot[moved] = slot;
            end
            handle_live[hid] = 1'b0;
            n_live--;
          end else begin
            r.status = sidt_pkg::ST_NOT_LIVE;
          end
        end
        default: begin
          if (si < n_live) begin
            r.handle = slot_owner[si];
            r.value  = value_store[si];
          end else begin
            r.status = sidt_pkg::ST_BEYOND;
          end
        end
      endcase
      r.count = n_live[sidt_pkg::RES_COUNT_W-1:0];
      return r;
    endfunction

    function void note_beat(sidt_pkg::op_e op, logic [sidt_pkg::VALUE_W-1:0] v,
                            logic [sidt_pkg::HANDLE_W-1:0] h,
                            logic [sidt_pkg::SLOT_IN_W-1:0] si);
      expected_results.push_back(predict_table_op(op, v, h, si));
    endfunction

    task check_result(logic [1:0] st, logic [sidt_pkg::RES_HANDLE_W-1:0] rh,
                      logic [sidt_pkg::VALUE_W-1:0] rv,
                      logic [sidt_pkg::RES_COUNT_W-1:0] cnt);
      table_result_t e;
      n_results++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
        return;
      end
      e = expected_results.pop_front();
      if (st !== e.status)
        report_mismatch($sformatf("result %0d status %0h, want %s", n_results, st,
                                  e.status.name()));
      if (rh !== e.handle)
        report_mismatch($sformatf("result %0d handle %0h, want %0h", n_results, rh, e.handle));
      if (rv !== e.value)
        report_mismatch($sformatf("result %0d value %0h, want %0h", n_results, rv, e.value));
      if (cnt !== e.count)
        report_mismatch($sformatf("result %0d live count %0d, want %0d", n_results, cnt,
                                  e.count));
    endtask

    function bit [sidt_pkg::HANDLE_W-1:0] any_live_handle();
      return sidt_pkg::HANDLE_W'(slot_owner[$urandom_range(0, n_live - 1)]);
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic [1:0]                        opcode_i = sidt_pkg::OP_LOOKUP;
  logic [sidt_pkg::VALUE_W-1:0]      push_value_i = '0;
  logic [sidt_pkg::HANDLE_W-1:0]     handle_i = '0;
  logic [sidt_pkg::SLOT_IN_W-1:0]    slot_index_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [1:0]                        status_o;
  logic [sidt_pkg::RES_HANDLE_W-1:0] result_handle_o;
  logic [sidt_pkg::VALUE_W-1:0]      result_value_o;
  logic [sidt_pkg::RES_COUNT_W-1:0]  live_count_o;

  handle_table_scoreboard sb;

  // Idling on both sides while set; cleared for the closing stretch.
  bit idle_on = 1'b1;
  // Request for one long receiver hold-off, so the block fills and stalls its input.
  bit hold_req = 1'b0;
  // Sender-side quiet stretch flag.
  bit send_quiet = 1'b0;

  stable_id_dense_table u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .push_value_i   (push_value_i),
    .handle_i       (handle_i),
    .slot_index_i   (slot_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_handle_o(result_handle_o),
    .result_value_o (result_value_o),
    .live_count_o   (live_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Generous ceiling: worst case is every beat waiting out a full sender gap, the block's
  // slowest erase and a full receiver stall, over roughly fourteen hundred beats.
  initial begin : watchdog
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one input beat and return at the edge that accepts it. Valid is left high;
  // the next call or the end of the run decides whether it drops.
  task automatic send_item(sidt_pkg::op_e op, logic [sidt_pkg::VALUE_W-1:0] v,
                           logic [sidt_pkg::HANDLE_W-1:0] h,
                           logic [sidt_pkg::SLOT_IN_W-1:0] si);
    int gap;
    if ($urandom_range(0, 39) == 0) send_quiet = ~send_quiet;
    if (idle_on && !send_quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    push_value_i <= v;
    handle_i     <= h;
    slot_index_i <= si;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_beat(op, v, h, si);
  endtask

  function automatic logic [sidt_pkg::VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly live handles; the rest dead, never issued, aliasing above the handle space or wild.
  function automatic logic [sidt_pkg::HANDLE_W-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        return (sb.n_live > 0) ? sb.any_live_handle()
                               : sidt_pkg::HANDLE_W'($urandom_range(0, 3));
      6: return (sb.next_id > 0) ? sidt_pkg::HANDLE_W'($urandom_range(0, sb.next_id - 1))
                                 : '0;
      7: return sidt_pkg::HANDLE_W'(sb.next_id + $urandom_range(0, 1));
      8: return $urandom;
      default: return {HIGH_W'($urandom_range(1, 2**HIGH_W - 1)), sidt_pkg::HID_W'($urandom)};
    endcase
  endfunction

  function automatic logic [sidt_pkg::SLOT_IN_W-1:0] pick_slot();
    case ($urandom_range(0, 9))
      0:       return sidt_pkg::SLOT_IN_W'($urandom);
      1:       return sidt_pkg::SLOT_IN_W'(sb.n_live);
      2:       return '1;
      default: return (sb.n_live > 0) ? sidt_pkg::SLOT_IN_W'($urandom_range(0, sb.n_live - 1))
                                      : sidt_pkg::SLOT_IN_W'($urandom);
    endcase
  endfunction

  task automatic send_random(int unsigned push_weight);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_weight)
      send_item(sidt_pkg::OP_PUSH, rand_value(), $urandom, sidt_pkg::SLOT_IN_W'($urandom));
    else if (r < push_weight + (100 - push_weight) / 3)
      send_item(sidt_pkg::OP_LOOKUP, rand_value(), pick_handle(),
                sidt_pkg::SLOT_IN_W'($urandom));
    else if (r < push_weight + 2 * (100 - push_weight) / 3)
      send_item(sidt_pkg::OP_ERASE, rand_value(), pick_handle(),
                sidt_pkg::SLOT_IN_W'($urandom));
    else
      send_item(sidt_pkg::OP_READ_SLOT, rand_value(), $urandom, pick_slot());
  endtask

  // Result side: checks every accepted beat and applies stall bursts or the long hold.
  initial begin : result_side
    int  stall_left;
    bit  recv_quiet;
    stall_left = 0;
    recv_quiet = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result(status_o, result_handle_o, result_value_o, live_count_o);
      if ($urandom_range(0, 63) == 0) recv_quiet = ~recv_quiet;
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 400;
      end else if (stall_left == 0 && idle_on && !recv_quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned wait_cycles;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: nothing live, every slot beyond the count
    send_item(sidt_pkg::OP_LOOKUP,    '0, 32'h0,        '0);
    send_item(sidt_pkg::OP_ERASE,     '0, 32'h0,        '0);
    send_item(sidt_pkg::OP_READ_SLOT, '0, 32'h0,        10'd0);
    send_item(sidt_pkg::OP_READ_SLOT, '1, '1,           10'd1023);
    send_item(sidt_pkg::OP_LOOKUP,    '1, 32'hFFFF_FFFF, '1);
    // Value extremes
    send_item(sidt_pkg::OP_PUSH, 64'h0,                   '0, '0);
    send_item(sidt_pkg::OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1);
    send_item(sidt_pkg::OP_PUSH, 64'h5555_5555_5555_5555, '0, '0);
    send_item(sidt_pkg::OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0);
    send_item(sidt_pkg::OP_LOOKUP, '0, 32'd1, '0);
    // Handles past the handle space alias live ones in their low bits but are not live
    send_item(sidt_pkg::OP_LOOKUP, '0, 32'h0000_1000, '0);
    send_item(sidt_pkg::OP_LOOKUP, '0, 32'h8000_0001, '0);
    send_item(sidt_pkg::OP_READ_SLOT, '0, '0, 10'd3);
    send_item(sidt_pkg::OP_READ_SLOT, '0, '0, 10'd4);
    // Erase of the last slot moves nothing; erase of slot 0 pulls the last entry down
    send_item(sidt_pkg::OP_ERASE, '0, 32'd3, '0);
    send_item(sidt_pkg::OP_ERASE, '0, 32'd0, '0);
    send_item(sidt_pkg::OP_READ_SLOT, '0, '0, 10'd0);
    send_item(sidt_pkg::OP_LOOKUP, '0, 32'd2, '0);
    // Dead and wild erases change nothing
    send_item(sidt_pkg::OP_ERASE, '0, 32'd0, '0);
    send_item(sidt_pkg::OP_ERASE, '0, 32'hFFFF_FFFF, '0);
    send_item(sidt_pkg::OP_LOOKUP, '0, 32'd3, '0);
    send_item(sidt_pkg::OP_ERASE, '0, 32'h0000_1001, '0);
    send_item(sidt_pkg::OP_LOOKUP, '0, 32'd1, '0);
    send_item(sidt_pkg::OP_READ_SLOT, '0, '0, 10'd1023);

    // Mixed traffic, push-heavy so the table grows; long hold-off part way in
    for (n = 0; n < 350; n++) begin
      if (n == 150) hold_req = 1'b1;
      send_random(60);
    end

    // Fill the value store, then push into a full store
    while (sb.n_live < sidt_pkg::DATA_DEPTH) begin
      if ($urandom_range(0, 7) == 0) send_random(0);
      else send_item(sidt_pkg::OP_PUSH, rand_value(), $urandom,
                     sidt_pkg::SLOT_IN_W'($urandom));
    end
    repeat (3) send_item(sidt_pkg::OP_PUSH, rand_value(), $urandom,
                         sidt_pkg::SLOT_IN_W'($urandom));

    // Closing stretch at full rate: mixed traffic from a full store
    idle_on = 1'b0;
    for (n = 0; n < 60; n++) send_random(20);
    send_item(sidt_pkg::OP_READ_SLOT, '0, '0, 10'd0);
    send_item(sidt_pkg::OP_PUSH, '1, '0, '0);
    send_item(sidt_pkg::OP_LOOKUP, '0, 32'd4095, '0);
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (sb.expected_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.expected_results.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_results.size()));

    if (sb.n_mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
sv/sidt_pkg.sv
sv/sidt_datapath.sv
sv/sidt_ctrl.sv
sv/stable_id_dense_table.sv
test/stable_id_dense_table_tb.sv
